FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GMDC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge out of reset
`define GMDC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: sv/gmdc_pkg.sv
// ----------------------------------------------------------------------------
// gmdc_pkg
// types, constants and the gram table of the gram match digit coder
// ----------------------------------------------------------------------------
package gmdc_pkg;

  localparam int unsigned CODE_DIGITS_DEF = 8;
  localparam int unsigned MAX_WORD_DEF    = 255;
  localparam int unsigned GRAM_COUNT      = 55;
  localparam int unsigned LenW            = 9;
  localparam logic [4:0]  DIGIT_BASE      = 5'd10;

  typedef struct packed {
    logic [7:0] g0;
    logic [7:0] g1;
    logic [7:0] g2;
    logic [1:0] glen;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [1:0] dlen;
  } gram_t;

  typedef struct packed {
    logic [1:0] used;
    logic [1:0] ndig;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
  } match_t;

  typedef struct packed {
    logic add_en;
    logic clr;
  } ring_ctrl_t;

  function automatic gram_t mk(input logic [7:0] g0, input logic [7:0] g1,
                               input logic [7:0] g2, input logic [1:0] glen,
                               input logic [3:0] d0, input logic [3:0] d1,
                               input logic [3:0] d2, input logic [1:0] dlen);
    gram_t e;
    e.g0 = g0; e.g1 = g1; e.g2 = g2; e.glen = glen;
    e.d0 = d0; e.d1 = d1; e.d2 = d2; e.dlen = dlen;
    return e;
  endfunction

  // gram entry, table order gives priority
  function automatic gram_t gram_entry(input logic [5:0] idx);
    gram_t e;
    unique case (idx)
      6'd0:  e = mk(" ", 8'h00, 8'h00, 2'd1, 4'd9, 4'd5, 4'd0, 2'd3);
      6'd1:  e = mk("s", "c", "h",     2'd3, 4'd8, 4'd0, 4'd0, 2'd2);
      6'd2:  e = mk("v", "e", "r",     2'd3, 4'd8, 4'd9, 4'd0, 2'd2);
      6'd3:  e = mk("a", "b", 8'h00,   2'd2, 4'd5, 4'd1, 4'd0, 2'd2);
      6'd4:  e = mk("a", "g", 8'h00,   2'd2, 4'd5, 4'd2, 4'd0, 2'd2);
      6'd5:  e = mk("a", "m", 8'h00,   2'd2, 4'd5, 4'd3, 4'd0, 2'd2);
      6'd6:  e = mk("a", "u", 8'h00,   2'd2, 4'd5, 4'd4, 4'd0, 2'd2);
      6'd7:  e = mk("b", "e", 8'h00,   2'd2, 4'd5, 4'd6, 4'd0, 2'd2);
      6'd8:  e = mk("c", "h", 8'h00,   2'd2, 4'd5, 4'd7, 4'd0, 2'd2);
      6'd9:  e = mk("c", "k", 8'h00,   2'd2, 4'd5, 4'd8, 4'd0, 2'd2);
      6'd10: e = mk("d", "e", 8'h00,   2'd2, 4'd6, 4'd0, 4'd0, 2'd2);
      6'd11: e = mk("f", "r", 8'h00,   2'd2, 4'd6, 4'd2, 4'd0, 2'd2);
      6'd12: e = mk("g", "e", 8'h00,   2'd2, 4'd6, 4'd4, 4'd0, 2'd2);
      6'd13: e = mk("k", "l", 8'h00,   2'd2, 4'd6, 4'd7, 4'd0, 2'd2);
      6'd14: e = mk("m", "a", 8'h00,   2'd2, 4'd7, 4'd0, 4'd0, 2'd2);
      6'd15: e = mk("m", "i", 8'h00,   2'd2, 4'd7, 4'd1, 4'd0, 2'd2);
      6'd16: e = mk("n", "d", 8'h00,   2'd2, 4'd7, 4'd2, 4'd0, 2'd2);
      6'd17: e = mk("n", "g", 8'h00,   2'd2, 4'd7, 4'd3, 4'd0, 2'd2);
      6'd18: e = mk("n", "t", 8'h00,   2'd2, 4'd7, 4'd4, 4'd0, 2'd2);
      6'd19: e = mk("q", "u", 8'h00,   2'd2, 4'd7, 4'd7, 4'd0, 2'd2);
      6'd20: e = mk("r", "a", 8'h00,   2'd2, 4'd7, 4'd9, 4'd0, 2'd2);
      6'd21: e = mk("s", "p", 8'h00,   2'd2, 4'd8, 4'd1, 4'd0, 2'd2);
      6'd22: e = mk("s", "t", 8'h00,   2'd2, 4'd8, 4'd2, 4'd0, 2'd2);
      6'd23: e = mk("t", "r", 8'h00,   2'd2, 4'd8, 4'd4, 4'd0, 2'd2);
      6'd24: e = mk("t", "z", 8'h00,   2'd2, 4'd8, 4'd5, 4'd0, 2'd2);
      6'd25: e = mk("u", "n", 8'h00,   2'd2, 4'd8, 4'd7, 4'd0, 2'd2);
      6'd26: e = mk("w", "a", 8'h00,   2'd2, 4'd9, 4'd1, 4'd0, 2'd2);
      6'd27: e = mk("w", "i", 8'h00,   2'd2, 4'd9, 4'd2, 4'd0, 2'd2);
      6'd28: e = mk("e", 8'h00, 8'h00, 2'd1, 4'd1, 4'd0, 4'd0, 2'd1);
      6'd29: e = mk("n", 8'h00, 8'h00, 2'd1, 4'd2, 4'd0, 4'd0, 2'd1);
      6'd30: e = mk("i", 8'h00, 8'h00, 2'd1, 4'd3, 4'd0, 4'd0, 2'd1);
      6'd31: e = mk("s", 8'h00, 8'h00, 2'd1, 4'd4, 4'd0, 4'd0, 2'd1);
      6'd32: e = mk("a", 8'h00, 8'h00, 2'd1, 4'd5, 4'd0, 4'd0, 2'd2);
      6'd33: e = mk("b", 8'h00, 8'h00, 2'd1, 4'd5, 4'd5, 4'd0, 2'd2);
      6'd34: e = mk("d", 8'h00, 8'h00, 2'd1, 4'd5, 4'd9, 4'd0, 2'd2);
      6'd35: e = mk("f", 8'h00, 8'h00, 2'd1, 4'd6, 4'd1, 4'd0, 2'd2);
      6'd36: e = mk("g", 8'h00, 8'h00, 2'd1, 4'd6, 4'd3, 4'd0, 2'd2);
      6'd37: e = mk("h", 8'h00, 8'h00, 2'd1, 4'd6, 4'd5, 4'd0, 2'd2);
      6'd38: e = mk("k", 8'h00, 8'h00, 2'd1, 4'd6, 4'd6, 4'd0, 2'd2);
      6'd39: e = mk("l", 8'h00, 8'h00, 2'd1, 4'd6, 4'd8, 4'd0, 2'd2);
      6'd40: e = mk("m", 8'h00, 8'h00, 2'd1, 4'd6, 4'd9, 4'd0, 2'd2);
      6'd41: e = mk("o", 8'h00, 8'h00, 2'd1, 4'd7, 4'd5, 4'd0, 2'd2);
      6'd42: e = mk("p", 8'h00, 8'h00, 2'd1, 4'd7, 4'd6, 4'd0, 2'd2);
      6'd43: e = mk("r", 8'h00, 8'h00, 2'd1, 4'd7, 4'd8, 4'd0, 2'd2);
      6'd44: e = mk("t", 8'h00, 8'h00, 2'd1, 4'd8, 4'd3, 4'd0, 2'd2);
      6'd45: e = mk("u", 8'h00, 8'h00, 2'd1, 4'd8, 4'd6, 4'd0, 2'd2);
      6'd46: e = mk("v", 8'h00, 8'h00, 2'd1, 4'd8, 4'd8, 4'd0, 2'd2);
      6'd47: e = mk("w", 8'h00, 8'h00, 2'd1, 4'd9, 4'd0, 4'd0, 2'd2);
      6'd48: e = mk("z", 8'h00, 8'h00, 2'd1, 4'd9, 4'd3, 4'd0, 2'd2);
      6'd49: e = mk(8'hDF, 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd2, 2'd3);
      6'd50: e = mk("c", 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd3, 2'd3);
      6'd51: e = mk("j", 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd4, 2'd3);
      6'd52: e = mk("q", 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd5, 2'd3);
      6'd53: e = mk("x", 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd6, 2'd3);
      6'd54: e = mk("y", 8'h00, 8'h00, 2'd1, 4'd9, 4'd6, 4'd7, 2'd3);
      default: e = mk(8'h00, 8'h00, 8'h00, 2'd3, 4'd0, 4'd0, 4'd0, 2'd0);
    endcase
    return e;
  endfunction

  // accent folding and ascii lowercasing
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'hE4, 8'hC4, 8'hE2, 8'hC2, 8'hE1, 8'hC1, 8'hE0, 8'hC0: r = "a";
      8'hF6, 8'hD6, 8'hF4, 8'hD4, 8'hF3, 8'hD3, 8'hF2, 8'hD2: r = "o";
      8'hFC:   r = "u";
      default: r = (c >= "A" && c <= "Z") ? (c + 8'd32) : c;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/gmdc_matcher.sv
// ----------------------------------------------------------------------------
// gmdc_matcher
// greedy first-hit match of the character window against the gram table
// ----------------------------------------------------------------------------
module gmdc_matcher (
  input  logic [7:0]      win0_i,
  input  logic [7:0]      win1_i,
  input  logic [7:0]      win2_i,
  input  logic [1:0]      fill_i,
  output gmdc_pkg::match_t match_o
);
  import gmdc_pkg::*;

  gram_t      e;
  logic       hit;
  logic       found;
  gram_t      best;

  always_comb begin
    found = 1'b0;
    best  = gram_entry(6'd0);
    e     = gram_entry(6'd0);
    hit   = 1'b0;
    // walk down so the lowest table index wins
    for (int i = GRAM_COUNT - 1; i >= 0; i--) begin
      e   = gram_entry(6'(i));
      hit = (e.glen <= fill_i) &&
            (e.glen < 2'd1 || win0_i == e.g0) &&
            (e.glen < 2'd2 || win1_i == e.g1) &&
            (e.glen < 2'd3 || win2_i == e.g2);
      if (hit) begin
        found = 1'b1;
        best  = e;
      end
    end
    match_o.d0 = best.d0;
    match_o.d1 = best.d1;
    match_o.d2 = best.d2;
    if (found) begin
      match_o.used = best.glen;
      match_o.ndig = best.dlen;
    end else begin
      match_o.used = (fill_i == 2'd0) ? 2'd0 : 2'd1;
      match_o.ndig = 2'd0;
    end
  end

endmodule

FILE: sv/gmdc_ring.sv
// ----------------------------------------------------------------------------
// gmdc_ring
// code digit ring with one shared mod-10 adder on a single access port
// ----------------------------------------------------------------------------
module gmdc_ring #(
  parameter int unsigned CODE_DIGITS = gmdc_pkg::CODE_DIGITS_DEF,
  parameter int unsigned PosW        = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gmdc_pkg::ring_ctrl_t ctrl_i,
  input  logic [PosW-1:0]      addr_i,
  input  logic [3:0]           add_val_i,
  output logic [3:0]           rd_digit_o
);
  import gmdc_pkg::*;

  logic [3:0] ring_q [CODE_DIGITS];
  logic [4:0] sum;
  logic [4:0] wrapped;

  assign rd_digit_o = ring_q[addr_i];
  assign sum        = {1'b0, rd_digit_o} + {1'b0, add_val_i};
  assign wrapped    = (sum >= DIGIT_BASE) ? (sum - DIGIT_BASE) : sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_DIGITS; i++) ring_q[i] <= 4'd0;
    end else if (ctrl_i.clr) begin
      for (int i = 0; i < CODE_DIGITS; i++) ring_q[i] <= 4'd0;
    end else if (ctrl_i.add_en) begin
      ring_q[addr_i] <= wrapped[3:0];
    end
  end

endmodule

FILE: sv/gram_match_digit_code_top.sv
// ----------------------------------------------------------------------------
// gram_match_digit_code_top
// word coder: folded characters matched against a gram table, digits summed
// mod 10 into a ring of code digits, ring emitted at end of word
// ----------------------------------------------------------------------------
// Rate: an input item is taken when the block is idle; when the three-character
// window fills, or at end of word while characters remain, each consumed gram
// takes a match step plus one add step per digit it adds (up to three), because
// the digit ring has a single mod-10 adder on one access port. An end-of-word
// item flushes at most three grams and then emits CODE_DIGITS items, one per
// cycle while the sink is ready; a word longer than MAX_WORD gives a single
// error item instead. The block is not ready for input while it matches, adds
// or emits.
`include "assert_macros.svh"

module gram_match_digit_code_top #(
  parameter int unsigned CODE_DIGITS = gmdc_pkg::CODE_DIGITS_DEF,
  parameter int unsigned MAX_WORD    = gmdc_pkg::MAX_WORD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] char_valid
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] digit, [7:4] zero
  output logic       m_axis_tuser,   // [0] too_long
  output logic       m_axis_tlast
);
  import gmdc_pkg::*;

  localparam int unsigned PosW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(CODE_DIGITS - 1);
  localparam logic [LenW-1:0] LenMax  = LenW'(MAX_WORD);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MATCH = 5'b00010,
    ST_ADD   = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_ERR   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [7:0]      win_q [3];
  logic [7:0]      win_d [3];
  logic [1:0]      fill_q, fill_d;
  logic [LenW-1:0] len_q, len_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] emit_q, emit_d;
  logic            lastp_q, lastp_d;
  logic [3:0]      dig_q [3];
  logic [3:0]      dig_d [3];
  logic [1:0]      ndig_q, ndig_d;
  logic [1:0]      cnt_q, cnt_d;

  match_t          match;
  ring_ctrl_t      ring_ctrl;
  logic [PosW-1:0] ring_addr;
  logic [3:0]      ring_rd;
  logic            in_acc;
  logic            out_acc;
  logic [LenW-1:0] len_new;
  logic            len_inc;
  logic [1:0]      fill_new;
  state_e          post_state;
  logic [1:0]      post_fill;
  logic [PosW-1:0] pos_next;

  gmdc_matcher u_matcher (
    .win0_i  (win_q[0]),
    .win1_i  (win_q[1]),
    .win2_i  (win_q[2]),
    .fill_i  (fill_q),
    .match_o (match)
  );

  gmdc_ring #(
    .CODE_DIGITS (CODE_DIGITS),
    .PosW        (PosW)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ring_ctrl),
    .addr_i     (ring_addr),
    .add_val_i  (dig_q[cnt_q]),
    .rd_digit_o (ring_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_EMIT) || (state_q == ST_ERR);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign ring_addr     = (state_q == ST_EMIT) ? emit_q : pos_q;
  assign m_axis_tdata  = (state_q == ST_EMIT) ? {4'd0, ring_rd} : 8'd0;
  assign m_axis_tuser  = (state_q == ST_ERR);
  assign m_axis_tlast  = (state_q == ST_ERR) || (emit_q == PosLast);
  assign pos_next      = (pos_q == PosLast) ? '0 : pos_q + 1'b1;

  assign len_inc  = s_axis_tuser && (len_q <= LenMax);
  assign len_new  = len_inc ? len_q + 1'b1 : len_q;

  // where to go once a gram has been fully applied
  always_comb begin
    post_fill = (state_q == ST_MATCH) ? fill_q - match.used : fill_q;
    if (lastp_q && post_fill != 2'd0) begin
      post_state = ST_MATCH;
    end else if (lastp_q) begin
      post_state = ST_EMIT;
    end else begin
      post_state = ST_IDLE;
    end
  end

  always_comb begin
    state_d   = state_q;
    win_d     = win_q;
    fill_d    = fill_q;
    len_d     = len_q;
    pos_d     = pos_q;
    emit_d    = emit_q;
    lastp_d   = lastp_q;
    dig_d     = dig_q;
    ndig_d    = ndig_q;
    cnt_d     = cnt_q;
    fill_new  = fill_q;
    ring_ctrl = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          len_d = len_new;
          if (len_inc && len_new <= LenMax) begin
            win_d[fill_q] = fold_char(s_axis_tdata);
            fill_new      = fill_q + 1'b1;
          end
          fill_d  = fill_new;
          lastp_d = s_axis_tlast;
          if (s_axis_tlast) begin
            if (len_new > LenMax) begin
              state_d = ST_ERR;
            end else if (fill_new != 2'd0) begin
              state_d = ST_MATCH;
            end else begin
              state_d = ST_EMIT;
            end
          end else if (fill_new == 2'd3) begin
            state_d = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        dig_d[0] = match.d0;
        dig_d[1] = match.d1;
        dig_d[2] = match.d2;
        ndig_d   = match.ndig;
        cnt_d    = 2'd0;
        unique case (match.used)
          2'd1: begin
            win_d[0] = win_q[1];
            win_d[1] = win_q[2];
            win_d[2] = 8'd0;
          end
          2'd2: begin
            win_d[0] = win_q[2];
            win_d[1] = 8'd0;
            win_d[2] = 8'd0;
          end
          2'd3: begin
            win_d[0] = 8'd0;
            win_d[1] = 8'd0;
            win_d[2] = 8'd0;
          end
          default: ;
        endcase
        fill_d  = fill_q - match.used;
        state_d = (match.ndig != 2'd0) ? ST_ADD : post_state;
      end
      ST_ADD: begin
        ring_ctrl.add_en = 1'b1;
        pos_d            = pos_next;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == ndig_q - 1'b1) begin
          state_d = post_state;
        end
      end
      ST_EMIT, ST_ERR: begin
        if (out_acc) begin
          if (state_q == ST_EMIT && emit_q != PosLast) begin
            emit_d = emit_q + 1'b1;
          end else begin
            ring_ctrl.clr = 1'b1;
            win_d[0]      = 8'd0;
            win_d[1]      = 8'd0;
            win_d[2]      = 8'd0;
            fill_d        = 2'd0;
            len_d         = '0;
            pos_d         = '0;
            emit_d        = '0;
            lastp_d       = 1'b0;
            state_d       = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      win_q[0] <= 8'd0;
      win_q[1] <= 8'd0;
      win_q[2] <= 8'd0;
      fill_q   <= 2'd0;
      len_q    <= '0;
      pos_q    <= '0;
      emit_q   <= '0;
      lastp_q  <= 1'b0;
      ndig_q   <= 2'd0;
      cnt_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      win_q   <= win_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      emit_q  <= emit_d;
      lastp_q <= lastp_d;
      ndig_q  <= ndig_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  `GMDC_ASSERT_NEVER(a_in_out_excl, s_axis_tready && m_axis_tvalid)
  `GMDC_ASSERT(a_idle_window, (state_q == ST_IDLE) |-> (fill_q != 2'd3))
  `GMDC_ASSERT(a_add_count, (state_q == ST_ADD) |-> (ndig_q != 2'd0 && cnt_q < ndig_q))
  `GMDC_ASSERT(a_err_is_last, (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)

endmodule
